>>> rtl/lzss_pkg.sv
// ============================================================================
// lzss_pkg
// Shared types and constants for the LZSS stream decompressor: window
// geometry, the restart pointer, the fill byte and the window request record.
// ============================================================================
package lzss_pkg;

    localparam int WinAw    = 12;
    localparam int WinDepth = 1 << WinAw;

    localparam logic [WinAw-1:0] PtrStart = WinAw'(4078);
    localparam logic [7:0]       FillByte = 8'h20;

    // Request from the sequencer to the history window
    typedef struct packed {
        logic             restart;
        logic             wr_en;
        logic [7:0]       wr_data;
        logic             rd_en;
        logic [WinAw-1:0] rd_addr;
    } win_req_t;

endpackage

>>> rtl/lzss_window.sv
// ============================================================================
// lzss_window
// 4096-byte history window with its wrapping write pointer. A fill count
// records how many bytes have been written since restart; an entry outside
// that span reads as a space, so no clearing pass is needed.
// ============================================================================
module lzss_window (
    input  logic             clk,
    input  logic             rst_n,
    input  lzss_pkg::win_req_t req,
    output logic [7:0]       rd_data
);
    import lzss_pkg::*;

    logic [7:0]       win_mem [WinDepth];
    logic [7:0]       q_reg;
    logic [WinAw-1:0] wptr_reg;
    logic [WinAw-1:0] wptr_next;
    logic [WinAw:0]   fill_reg;
    logic [WinAw:0]   fill_next;
    logic             hit_reg;
    logic             hit_next;
    logic [WinAw-1:0] rd_offset;

    // Write at the pointer, registered read at the requested address
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            win_mem[wptr_reg] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= win_mem[req.rd_addr];
        end
    end

    // Distance of the read address from the restart point
    assign rd_offset = req.rd_addr - PtrStart;

    // Advance pointer and fill count, hold the hit flag with the read data
    always_comb
    begin
        wptr_next = wptr_reg;
        fill_next = fill_reg;
        hit_next  = hit_reg;
        if (req.restart)
        begin
            wptr_next = PtrStart;
            fill_next = '0;
        end
        else if (req.wr_en)
        begin
            wptr_next = wptr_reg + 1'b1;
            if (fill_reg != (WinAw+1)'(WinDepth))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
        if (req.rd_en)
        begin
            hit_next = {1'b0, rd_offset} < fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= PtrStart;
            fill_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            fill_reg <= fill_next;
            hit_reg  <= hit_next;
        end
    end

    // Unwritten entries read as the fill byte
    assign rd_data = hit_reg ? q_reg : FillByte;

endmodule

>>> rtl/lzss_stream_decompressor.sv
// Sequencing: a flag byte or the first byte of a match is taken in the idle state.
// A literal passes through emit; a match alternates read and emit for each byte,
// since each copied byte is a window read followed by its write-back through the
// single window port. Emit waits out output stalls; the result shows the cycle after.
// Reset: window reads as spaces, pointer 4078, no clearing pass.
// ============================================================================
// lzss_stream_decompressor
// Token parser and copy sequencer for an LZSS stream with a 4096-byte
// window; emits the decompressed bytes of each token on the output channel.
// ============================================================================
module lzss_stream_decompressor (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] packed_byte,
    input  logic       new_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last
);
    import lzss_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StRead = 2'd1;
    localparam logic [1:0] StEmit = 2'd2;

    logic [1:0]       state_reg,     state_next;
    logic [7:0]       flag_bits_reg, flag_bits_next;
    logic [3:0]       flags_left_reg, flags_left_next;
    logic             phase_reg,     phase_next;
    logic [7:0]       held_low_reg,  held_low_next;
    logic [WinAw-1:0] copy_addr_reg, copy_addr_next;
    logic [4:0]       remain_reg,    remain_next;
    logic             is_lit_reg,    is_lit_next;
    logic [7:0]       lit_reg,       lit_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;
    logic             last_reg,      last_next;

    logic             accept;
    logic             out_free;
    logic [7:0]       eff_flag_bits;
    logic [3:0]       eff_flags_left;
    logic             eff_phase;
    logic [7:0]       rd_data;
    logic [7:0]       emit_data;
    win_req_t         win_req;

    lzss_window u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (win_req),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != StIdle);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Parser state as seen by this request, after an optional restart
    assign eff_flag_bits  = new_stream ? 8'h00 : flag_bits_reg;
    assign eff_flags_left = new_stream ? 4'h0  : flags_left_reg;
    assign eff_phase      = new_stream ? 1'b0  : phase_reg;

    assign emit_data = is_lit_reg ? lit_reg : rd_data;

    // Sequencer: parse tokens, then read and write back one byte at a time
    always_comb
    begin
        state_next      = state_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        phase_next      = phase_reg;
        held_low_next   = held_low_reg;
        copy_addr_next  = copy_addr_reg;
        remain_next     = remain_reg;
        is_lit_next     = is_lit_reg;
        lit_next        = lit_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        last_next       = last_reg;

        win_req         = '0;
        win_req.rd_addr = copy_addr_reg;
        win_req.wr_data = emit_data;

        unique case (state_reg)
            StIdle:
            begin
                if (accept)
                begin
                    win_req.restart = new_stream;
                    flag_bits_next  = eff_flag_bits;
                    flags_left_next = eff_flags_left;
                    phase_next      = 1'b0;
                    if (new_stream)
                    begin
                        held_low_next = 8'h00;
                    end
                    priority if (eff_phase)
                    begin
                        // Second match byte: start the copy
                        copy_addr_next  = {packed_byte[7:4], held_low_reg};
                        remain_next     = {1'b0, packed_byte[3:0]} + 5'd3;
                        is_lit_next     = 1'b0;
                        flag_bits_next  = eff_flag_bits >> 1;
                        flags_left_next = eff_flags_left - 4'd1;
                        state_next      = StRead;
                    end
                    else if (eff_flags_left == 4'h0)
                    begin
                        // Flag byte: load eight token flags
                        flag_bits_next  = packed_byte;
                        flags_left_next = 4'd8;
                    end
                    else if (eff_flag_bits[0])
                    begin
                        // Literal: emit and store it
                        lit_next        = packed_byte;
                        is_lit_next     = 1'b1;
                        flag_bits_next  = eff_flag_bits >> 1;
                        flags_left_next = eff_flags_left - 4'd1;
                        state_next      = StEmit;
                    end
                    else
                    begin
                        // First match byte: hold the low position bits
                        held_low_next = packed_byte;
                        phase_next    = 1'b1;
                    end
                end
            end

            StRead:
            begin
                win_req.rd_en = 1'b1;
                state_next    = StEmit;
            end

            StEmit:
            begin
                if (out_free)
                begin
                    win_req.wr_en  = 1'b1;
                    out_valid_next = 1'b1;
                    out_byte_next  = emit_data;
                    last_next      = is_lit_reg || (remain_reg == 5'd1);
                    if (is_lit_reg || (remain_reg == 5'd1))
                    begin
                        state_next = StIdle;
                    end
                    else
                    begin
                        copy_addr_next = copy_addr_reg + 1'b1;
                        remain_next    = remain_reg - 5'd1;
                        state_next     = StRead;
                    end
                end
            end

            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= StIdle;
            flag_bits_reg  <= 8'h00;
            flags_left_reg <= 4'h0;
            phase_reg      <= 1'b0;
            held_low_reg   <= 8'h00;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            phase_reg      <= phase_next;
            held_low_reg   <= held_low_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
        remain_reg    <= remain_next;
        is_lit_reg    <= is_lit_next;
        lit_reg       <= lit_next;
        out_byte_reg  <= out_byte_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the LZSS stream decompressor. A short table of
// compressed bytes (flag bytes, literal extremes, window position and length
// extremes, overlapping copies, restarts mid-token) is followed by random flag
// groups with random tokens. Every output byte and its last mark is compared
// against a fixed table value or a behavioural copy of the window decoder,
// under several patterns of sender gaps and receiver stalls.
// ============================================================================
module tb_top;
    import lzss_pkg::*;

    localparam int RandomItems = 220;
    localparam int QuietLimit  = 2000;
    localparam int DrainCycles = 48;

    typedef enum logic {
        TOKEN_START,
        MATCH_HIGH
    } parse_state_t;

    // One row of directed stimulus; fixed_out rows carry their own expectation
    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
        logic       fixed_out;
        logic [4:0] n_out;
        logic [7:0] out_value;
    } stim_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [7:0] packed_byte = 8'h00;
    logic       new_stream  = 1'b0;
    logic       out_stall   = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       last;

    // Decoder copy: window, write pointer and token parser
    logic [7:0]       window_copy [WinDepth];
    logic [WinAw-1:0] copy_ptr;
    logic [7:0]       copy_flags;
    logic [3:0]       copy_flags_left;
    parse_state_t     copy_state;
    logic [7:0]       copy_pos_low;

    logic [7:0] expected_bytes [$];
    logic       expected_last  [$];

    int         error_count = 0;
    int         quiet_cycles = 0;
    int         idle_pct = 0;
    int         stall_pct = 0;
    logic [7:0] want_byte;
    logic       want_last;

    stim_row_t directed_rows [24] = '{
        '{8'hFC, 1'b1, 1'b1, 5'd0,  8'h00},
        '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h00, 1'b0, 1'b1, 5'd3,  8'h20},
        '{8'hFF, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'hFF, 1'b0, 1'b1, 5'd18, 8'h20},
        '{8'h00, 1'b0, 1'b1, 5'd1,  8'h00},
        '{8'hFF, 1'b0, 1'b1, 5'd1,  8'hFF},
        '{8'h5A, 1'b0, 1'b1, 5'd1,  8'h5A},
        '{8'hA5, 1'b0, 1'b1, 5'd1,  8'hA5},
        '{8'h01, 1'b0, 1'b1, 5'd1,  8'h01},
        '{8'h80, 1'b0, 1'b1, 5'd1,  8'h80},
        '{8'h00, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h03, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h03, 1'b0, 1'b0, 5'd0,  8'h00},
        '{8'h0D, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h0F, 1'b0, 1'b0, 5'd0,  8'h00},
        '{8'h12, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h81, 1'b1, 1'b1, 5'd0,  8'h00},
        '{8'h7E, 1'b0, 1'b1, 5'd1,  8'h7E},
        '{8'hEE, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'hF2, 1'b0, 1'b0, 5'd0,  8'h00},
        '{8'h00, 1'b1, 1'b1, 5'd0,  8'h00},
        '{8'h10, 1'b0, 1'b1, 5'd0,  8'h00},
        '{8'h2F, 1'b0, 1'b1, 5'd18, 8'h20}
    };

    lzss_stream_decompressor DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .packed_byte (packed_byte),
        .new_stream  (new_stream),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Refill the window with spaces and rewind the parser
    task automatic restart_window();
        for (int i = 0; i < WinDepth; i++)
        begin
            window_copy[i] = FillByte;
        end
        copy_ptr        = PtrStart;
        copy_flags      = 8'h00;
        copy_flags_left = 4'd0;
        copy_state      = TOKEN_START;
        copy_pos_low    = 8'h00;
    endtask

    // Decode one compressed byte; queue the bytes it yields when asked to
    task automatic decode_request(input logic [7:0] b, input logic ns, input bit record);
        logic [WinAw-1:0] src;
        int               len;
        logic [7:0]       v;
        if (ns)
        begin
            restart_window();
        end
        if (copy_state == MATCH_HIGH)
        begin
            // Copy byte by byte so an overlapping source sees fresh writes
            src = {b[7:4], copy_pos_low};
            len = b[3:0] + 3;
            for (int i = 0; i < len; i++)
            begin
                v = window_copy[src];
                src++;
                window_copy[copy_ptr] = v;
                copy_ptr++;
                if (record)
                begin
                    expected_bytes.push_back(v);
                    expected_last.push_back(i == len - 1);
                end
            end
            copy_state = TOKEN_START;
            copy_flags = copy_flags >> 1;
            copy_flags_left--;
        end
        else if (copy_flags_left == 4'd0)
        begin
            copy_flags      = b;
            copy_flags_left = 4'd8;
        end
        else if (copy_flags[0])
        begin
            window_copy[copy_ptr] = b;
            copy_ptr++;
            if (record)
            begin
                expected_bytes.push_back(b);
                expected_last.push_back(1'b1);
            end
            copy_flags = copy_flags >> 1;
            copy_flags_left--;
        end
        else
        begin
            copy_pos_low = b;
            copy_state   = MATCH_HIGH;
        end
    endtask

    // Present one request after a random gap and hold it until taken
    task automatic send_request(input logic [7:0] b, input logic ns, input bit record);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        packed_byte <= b;
        new_stream  <= ns;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        decode_request(b, ns, record);
    endtask

    // Randomise receiver back-pressure
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Compare each accepted output byte with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $display("%0t: unexpected output, expected none, actual byte %h last %b",
                         $time, out_byte, last);
                error_count++;
            end
            else
            begin
                want_byte = expected_bytes.pop_front();
                want_last = expected_last.pop_front();
                if (out_byte !== want_byte)
                begin
                    $display("%0t: out_byte mismatch, expected %h actual %h",
                             $time, want_byte, out_byte);
                    error_count++;
                end
                if (last !== want_last)
                begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want_last, last);
                    error_count++;
                end
            end
        end
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QuietLimit)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        stim_row_t        row;
        logic [7:0]       flags;
        logic [WinAw-1:0] src_pos;
        logic [3:0]       len_code;
        bit               restart_next;
        int               sent;

        restart_window();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, no idling
        foreach (directed_rows[r])
        begin
            row = directed_rows[r];
            send_request(row.in_byte, row.restart, !row.fixed_out);
            if (row.fixed_out)
            begin
                for (int k = 0; k < row.n_out; k++)
                begin
                    expected_bytes.push_back(row.out_value);
                    expected_last.push_back(k == row.n_out - 1);
                end
            end
        end

        // Random flag groups, with truncated tokens and stray bytes now and then
        sent         = 0;
        restart_next = 1'b1;
        while (sent < RandomItems)
        begin
            case (sent * 4 / RandomItems)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 83; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 83; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            flags = 8'($urandom_range(255));
            send_request(flags, restart_next || ($urandom_range(19) == 0), 1'b1);
            sent++;
            restart_next = 1'b0;
            for (int t = 0; t < 8; t++)
            begin
                if ($urandom_range(24) == 0)
                begin
                    // Leave a dangling byte and resync with a restart
                    send_request(8'($urandom_range(255)), 1'b0, 1'b1);
                    sent++;
                    restart_next = 1'b1;
                    break;
                end
                if (flags[t])
                begin
                    send_request(8'($urandom_range(255)), 1'b0, 1'b1);
                    sent++;
                end
                else
                begin
                    // Mostly point just behind the write pointer to exercise overlap
                    if ($urandom_range(3) != 0)
                    begin
                        src_pos = copy_ptr - WinAw'($urandom_range(40, 1));
                    end
                    else
                    begin
                        src_pos = WinAw'($urandom_range(WinDepth - 1));
                    end
                    len_code = 4'($urandom_range(15));
                    send_request(src_pos[7:0], 1'b0, 1'b1);
                    send_request({src_pos[11:8], len_code}, 1'b0, 1'b1);
                    sent += 2;
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding bytes, then watch for strays
        while (expected_bytes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (error_count == 0 && expected_bytes.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
